// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// File: design/hftf_pkg.sv
// ----------------------------------------------------------------------------
// hftf_pkg
// types and constants of the hashed flow table
// ----------------------------------------------------------------------------
`default_nettype none

package hftf_pkg;

	localparam int KEY_W    = 32;
	localparam int CFG_W    = 13;
	localparam int CIDX_W   = 8;
	localparam int BIDX_W   = 12;
	localparam int WIDX_W   = 3;
	localparam int STAT_W   = 2;
	localparam int CFG_RST  = 4096;

	localparam logic [CIDX_W-1:0] REG_BUCKET_COUNT   = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_ENTRY_CAPACITY = CIDX_W'(1);

	localparam logic [STAT_W-1:0] ST_HIT     = STAT_W'(0);
	localparam logic [STAT_W-1:0] ST_NEW     = STAT_W'(1);
	localparam logic [STAT_W-1:0] ST_NO_FREE = STAT_W'(2);

	typedef struct packed {
		logic [KEY_W-1:0] flow_key_hash;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BIDX_W-1:0] bucket_index;
		logic [WIDX_W-1:0] way_index;
		logic              evicted_valid;
	} rsp_t;

	typedef struct packed {
		logic [CIDX_W-1:0] index;
		logic [CFG_W-1:0]  value;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/hftf_chan_if.sv
// ----------------------------------------------------------------------------
// hftf_chan_if
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
`default_nettype none

interface hftf_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/hashed_flow_table_fifo_ways.sv
// ----------------------------------------------------------------------------
// hashed_flow_table_fifo_ways
// set-associative flow table with per-bucket fifo replacement
// ----------------------------------------------------------------------------
// req carries one flow hash per transfer; rsp returns one result per request:
// status (hit, created, no free entry), bucket, way and an eviction flag.
// cfg writes bucket_count (index 0) and entry_capacity (index 1, which also
// reloads the free handle counter); it is always ready. It must be written
// only while the table is idle; the block itself does not enforce this.
// One request is in flight at a time. The bucket is found by a serial
// divider, then the bucket metadata is read (S_META, S_META_WT) and the
// ways are compared one at a time through the single hash memory port,
// each way taking a read state (S_RD) and a compare state (S_CMP), then
// S_DECIDE picks the result and writes a created entry. A hit returns early.
// req.ready is high only when no request is in flight.
// After reset the metadata memory is cleared, one bucket per cycle, with
// req.ready low. The hash memory is never cleared.
// The result is held in an output register while rsp.ready is low; the
// next request is taken after the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_flow_table_fifo_ways #(
	parameter int WAYS        = 8,
	parameter int MAX_BUCKETS = 4096,
	parameter int HASH_WIDTH  = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hftf_chan_if.sink   req,
	hftf_chan_if.source rsp,
	hftf_chan_if.sink   cfg
);
	import hftf_pkg::*;
	`include "assert_macros.svh"

	localparam int KW = (HASH_WIDTH < KEY_W) ? HASH_WIDTH : KEY_W;
	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int WW = $clog2(WAYS);
	localparam int SW = $clog2(WAYS);
	localparam int AW = $clog2(MAX_BUCKETS * WAYS);
	localparam int MW = WAYS + WW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV, S_META, S_META_WT, S_RD, S_CMP, S_DECIDE, S_OUT
	} state_t;

	state_t            st_q;
	logic [BW-1:0]     clr_q;
	logic [CFG_W-1:0]  bcount_q;
	logic [CFG_W-1:0]  cap_q;
	logic [CFG_W-1:0]  free_q;
	logic [KW-1:0]     hash_q;
	logic [BW-1:0]     bucket_q;
	logic [WAYS-1:0]   valid_q;
	logic [WW-1:0]     head_q;
	logic [WW-1:0]     way_q;
	logic [SW-1:0]     step_q;
	rsp_t              rsp_q;

	logic [MW-1:0]     meta_mem [MAX_BUCKETS];
	logic [MW-1:0]     meta_rd_q;
	logic [KW-1:0]     hash_mem [MAX_BUCKETS * WAYS];
	logic [KW-1:0]     hash_rd_q;

	logic              req_xfer;
	logic              div_done;
	logic [CFG_W-1:0]  div_rem;
	logic [CFG_W-1:0]  divisor;
	logic [WW-1:0]     slot;
	logic [WW-1:0]     way_nxt;
	logic              do_create;
	logic              meta_we;
	logic [BW-1:0]     meta_wa;
	logic [MW-1:0]     meta_wd;
	logic [AW-1:0]     hash_addr;
	logic [WW-1:0]     hash_way;

	assign req_xfer  = req.valid && req.ready;
	assign req.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = (st_q == S_OUT);
	assign rsp.data  = rsp_q;

	// clamp the divisor to 1..MAX_BUCKETS
	always_comb begin
		divisor = bcount_q;
		if (bcount_q == '0) begin
			divisor = CFG_W'(1);
		end else if (32'(bcount_q) > MAX_BUCKETS) begin
			divisor = CFG_W'(MAX_BUCKETS);
		end
	end

	hftf_div #(
		.NW (KW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_xfer),
		.dividend (KW'(req.data.flow_key_hash)),
		.divisor  (divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign slot      = (head_q == '0) ? WW'(WAYS - 1) : head_q - WW'(1);
	assign way_nxt   = (way_q == WW'(WAYS - 1)) ? '0 : way_q + WW'(1);
	assign do_create = (st_q == S_DECIDE) && (free_q != '0);

	// metadata port: clearing sweep or the create write-back
	always_comb begin
		meta_we = (st_q == S_CLEAR) || do_create;
		meta_wa = (st_q == S_CLEAR) ? clr_q : bucket_q;
		meta_wd = '0;
		if (st_q != S_CLEAR) begin
			meta_wd = {valid_q | (WAYS'(1) << slot), slot};
		end
	end

	assign hash_way  = (st_q == S_DECIDE) ? slot : way_q;
	assign hash_addr = AW'(AW'(bucket_q) * AW'(WAYS) + AW'(hash_way));

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (st_q == S_META) begin
			meta_rd_q <= meta_mem[bucket_q];
		end
	end

	always_ff @(posedge clk) begin
		if (do_create) begin
			hash_mem[hash_addr] <= hash_q;
		end
		if (st_q == S_RD) begin
			hash_rd_q <= hash_mem[hash_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			clr_q    <= '0;
			bcount_q <= CFG_W'(CFG_RST);
			cap_q    <= CFG_W'(CFG_RST);
			free_q   <= CFG_W'(CFG_RST);
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(MAX_BUCKETS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						hash_q <= KW'(req.data.flow_key_hash);
						st_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						bucket_q <= BW'(div_rem);
						st_q     <= S_META;
					end
				end
				S_META: begin
					st_q <= S_META_WT;
				end
				S_META_WT: begin
					valid_q <= meta_rd_q[MW-1:WW];
					head_q  <= meta_rd_q[WW-1:0];
					way_q   <= meta_rd_q[WW-1:0];
					step_q  <= '0;
					st_q    <= S_RD;
				end
				S_RD: begin
					st_q <= S_CMP;
				end
				S_CMP: begin
					if (valid_q[way_q] && hash_rd_q == hash_q) begin
						rsp_q.status        <= ST_HIT;
						rsp_q.bucket_index  <= BIDX_W'(bucket_q);
						rsp_q.way_index     <= WIDX_W'(way_q);
						rsp_q.evicted_valid <= 1'b0;
						st_q                <= S_OUT;
					end else if (step_q == SW'(WAYS - 1)) begin
						st_q <= S_DECIDE;
					end else begin
						step_q <= step_q + SW'(1);
						way_q  <= way_nxt;
						st_q   <= S_RD;
					end
				end
				S_DECIDE: begin
					rsp_q.bucket_index <= BIDX_W'(bucket_q);
					if (free_q == '0) begin
						rsp_q.status        <= ST_NO_FREE;
						rsp_q.way_index     <= '0;
						rsp_q.evicted_valid <= 1'b0;
					end else begin
						rsp_q.status        <= ST_NEW;
						rsp_q.way_index     <= WIDX_W'(slot);
						rsp_q.evicted_valid <= valid_q[slot];
						// evicting a valid entry hands its handle straight back
						if (!valid_q[slot]) begin
							free_q <= free_q - CFG_W'(1);
						end
					end
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
			if (cfg.valid) begin
				if (cfg.data.index == REG_BUCKET_COUNT) begin
					bcount_q <= cfg.data.value;
				end else if (cfg.data.index == REG_ENTRY_CAPACITY) begin
					cap_q  <= cfg.data.value;
					free_q <= cfg.data.value;
				end
			end
		end
	end

	`ASSERT_IMPL(a_one_in_flight, req.ready, !rsp.valid, "request taken while result pending")
	`ASSERT_CLK(a_free_le_cap, free_q <= cap_q, "free handle count above capacity")
	`ASSERT_IMPL(a_no_free_fields, rsp.valid && rsp.data.status == ST_NO_FREE,
		rsp.data.way_index == '0 && !rsp.data.evicted_valid, "no-free result with way data")

endmodule

`default_nettype wire

// File: design/hftf_div.sv
// ----------------------------------------------------------------------------
// hftf_div
// restoring serial divider, one dividend bit per cycle, remainder only
// ----------------------------------------------------------------------------
`default_nettype none

module hftf_div #(
	parameter int NW = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [NW-1:0]             dividend,
	input  wire logic [hftf_pkg::CFG_W-1:0] divisor,
	output logic                           done,
	output logic [hftf_pkg::CFG_W-1:0]     rem
);
	import hftf_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [NW-1:0]     num_q;
	logic [CFG_W-1:0]  den_q;
	logic [CFG_W:0]    rem_q;
	logic [CFG_W:0]    trial;
	logic [CFG_W:0]    diff;

	assign trial = {rem_q[CFG_W-1:0], num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= (trial >= {1'b0, den_q}) ? diff : trial;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[CFG_W-1:0];

endmodule

`default_nettype wire
